// ----- rtl/mp2d_pkg.sv -----
// Shared types, constants and register codes of the 2-D max pooling block.
`timescale 1ns / 1ps

package mp2d_pkg;

    // Defaults of the top-level size parameters
    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MAX_CHANNELS = 64;
    localparam int DEF_MAX_WINDOW   = 8;

    // Fixed field widths
    localparam int DATA_W  = 16;
    localparam int IDX_W   = 22;
    localparam int PHASE_W = 4;
    // Width for counter / register compares, and the divider width
    localparam int CMP_W   = 13;
    localparam int DIV_W   = 12;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_WIDTH    = 3'd1;
    localparam logic [2:0] REG_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_WINDOW   = 3'd3;
    localparam logic [2:0] REG_STEP     = 3'd4;

    typedef struct packed {
        logic [6:0] channel_count;
        logic [8:0] image_width;
        logic [8:0] image_height;
        logic [3:0] window_size;
        logic [3:0] step_size;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [3:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [3:0]       remainder;
    } t_div_rsp;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic [IDX_W-1:0] idx;
    } t_cmp_ctl;

endpackage

// ----- rtl/max_pool_2d_forward.sv -----
// Streaming 2-D max pooling, forward pass, signed Q8.8 samples.
//
//  Channel  | Dir | Signals                                  | Payload
//  ---------+-----+------------------------------------------+---------------------------
//  config   | in  | psel penable pwrite paddr pwdata prdata  | five registers at 4*i
//  samples  | in  | s_tvalid s_tready s_tdata s_tuser        | sample_value, frame_start
//  results  | out | m_tvalid m_tready m_tdata m_tlast        | pooled_value, winner_index
//
//  A sample that closes no window passes the transfer and the store write; one that closes
//  a window then goes through base, scan, drain and emit, the scan reading the K x K window
//  (K the window side) from the single-read-port row store through the shared compare unit.
//  After reset and after every register write the shared divider derives the last grid
//  column, last grid row and the row-store slot: for a usable set, s_tready stays low till done.
//  The result register lets the next sample in while a result waits; a second result
//  holds in the final state until m_tready frees the register.
`timescale 1ns / 1ps

module max_pool_2d_forward import mp2d_pkg::*; #(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_value
    input  logic [0:0]  s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [15:0] pooled_value, [37:16] winner_index, [39:38] zero
    output logic        m_tlast    // frame_done
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_WRITE = 10'b0000000010,
        S_BASE  = 10'b0000000100,
        S_SCAN  = 10'b0000001000,
        S_DRAIN = 10'b0000010000,
        S_EMIT  = 10'b0000100000,
        S_FIX   = 10'b0001000000,
        S_DCOL  = 10'b0010000000,
        S_DROW  = 10'b0100000000,
        S_DSLOT = 10'b1000000000
    } t_state;

    function automatic logic [PHASE_W-1:0] nph(input logic [PHASE_W-1:0] p,
                                               input logic [3:0] s);
        return (({1'b0, p} + 1'b1) >= {1'b0, s}) ? '0 : p + 1'b1;
    endfunction

    t_cfg     cfg;
    logic     cfg_wr;
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_cmp_ctl r_cmp;

    t_state               r_state;
    logic [DATA_W-1:0]    r_sample;
    logic                 r_fs;
    logic [CW-1:0]        r_col;
    logic [RW-1:0]        r_row;
    logic [CHW-1:0]       r_ch;
    logic [PHASE_W-1:0]   r_cph;
    logic [PHASE_W-1:0]   r_rph;
    logic [SW-1:0]        r_slot;
    logic [CMP_W-1:0]     r_last_col;
    logic [CMP_W-1:0]     r_last_row;
    logic                 r_last;
    logic [IDX_W-1:0]     r_mul_a;
    logic [IDX_W-1:0]     r_idx;
    logic [CW-1:0]        r_left;
    logic [CW-1:0]        r_rd_col;
    logic [SW-1:0]        r_rd_slot;
    logic [SW-1:0]        r_kx;
    logic [SW-1:0]        r_ky;

    logic                 r_out_vld;
    logic [DATA_W-1:0]    r_out_val;
    logic [IDX_W-1:0]     r_out_idx;
    logic                 r_out_last;

    logic [3:0]  k;
    logic [3:0]  s;
    logic [8:0]  w;
    logic [8:0]  h;
    logic [6:0]  cc;
    logic        usable;
    logic        outside;
    logic        on_grid;
    logic        emit_go;

    logic [CW-1:0]      p_col, c_col, a_col;
    logic [RW-1:0]      p_row, c_row, a_row;
    logic [CHW-1:0]     p_ch, c_ch, a_ch;
    logic [PHASE_W-1:0] p_cph, c_cph, a_cph;
    logic [PHASE_W-1:0] p_rph, c_rph, a_rph;
    logic [SW-1:0]      p_slot, c_slot, a_slot;

    logic              st_we;
    logic [AW-1:0]     st_waddr;
    logic [AW-1:0]     st_raddr;
    logic [DATA_W-1:0] st_rdata;
    logic [DATA_W-1:0] best_val;
    logic [IDX_W-1:0]  best_idx;

    mp2d_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg),
        .o_wr    (cfg_wr)
    );

    mp2d_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    mp2d_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (r_sample),
        .i_re    (r_state == S_SCAN),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    mp2d_max u_max (
        .i_clk      (i_clk),
        .i_ctl      (r_cmp),
        .i_data     (st_rdata),
        .o_best     (best_val),
        .o_best_idx (best_idx)
    );

    assign k  = cfg.window_size;
    assign s  = cfg.step_size;
    assign w  = cfg.image_width;
    assign h  = cfg.image_height;
    assign cc = cfg.channel_count;

    assign usable = (cc != 7'd0) && (CMP_W'(cc) <= CMP_W'(MAX_CHANNELS)) &&
                    (w != 9'd0) && (CMP_W'(w) <= CMP_W'(MAX_WIDTH)) &&
                    (h != 9'd0) && (CMP_W'(h) <= CMP_W'(MAX_HEIGHT)) &&
                    (k != 4'd0) && (CMP_W'(k) <= CMP_W'(MAX_WINDOW)) &&
                    (s != 4'd0) && (CMP_W'(k) <= CMP_W'(w)) && (CMP_W'(k) <= CMP_W'(h));

    // Position of the held sample: frame start clears, then a position outside the image
    always_comb begin
        p_col  = r_fs ? '0 : r_col;
        p_row  = r_fs ? '0 : r_row;
        p_ch   = r_fs ? '0 : r_ch;
        p_cph  = r_fs ? '0 : r_cph;
        p_rph  = r_fs ? '0 : r_rph;
        p_slot = r_fs ? '0 : r_slot;
        outside = (CMP_W'(p_col) >= CMP_W'(w)) || (CMP_W'(p_row) >= CMP_W'(h)) ||
                  (CMP_W'(p_ch) >= CMP_W'(cc));
        if (outside) begin
            p_col  = '0;
            p_row  = '0;
            p_ch   = '0;
            p_cph  = '0;
            p_rph  = '0;
            p_slot = '0;
        end
    end

    assign on_grid = (CMP_W'(p_col) + 1'b1 >= CMP_W'(k)) &&
                     (CMP_W'(p_row) + 1'b1 >= CMP_W'(k)) &&
                     (p_cph == '0) && (p_rph == '0);

    // Raster advance, from the held position during the store write, else from the counters
    always_comb begin
        c_col  = (r_state == S_WRITE) ? p_col  : r_col;
        c_row  = (r_state == S_WRITE) ? p_row  : r_row;
        c_ch   = (r_state == S_WRITE) ? p_ch   : r_ch;
        c_cph  = (r_state == S_WRITE) ? p_cph  : r_cph;
        c_rph  = (r_state == S_WRITE) ? p_rph  : r_rph;
        c_slot = (r_state == S_WRITE) ? p_slot : r_slot;
        a_col  = c_col + 1'b1;
        a_row  = c_row;
        a_ch   = c_ch;
        a_cph  = c_cph;
        a_rph  = c_rph;
        a_slot = c_slot;
        if (CMP_W'(c_col) + 1'b1 >= CMP_W'(k)) begin
            a_cph = nph(c_cph, s);
        end
        if (CMP_W'(c_col) + 1'b1 >= CMP_W'(w)) begin
            a_col = '0;
            a_cph = '0;
            if (CMP_W'(c_row) + 1'b1 >= CMP_W'(k)) begin
                a_rph = nph(c_rph, s);
            end
            if (CMP_W'(c_row) + 1'b1 >= CMP_W'(h)) begin
                a_row  = '0;
                a_rph  = '0;
                a_slot = '0;
                a_ch   = (CMP_W'(c_ch) + 1'b1 >= CMP_W'(cc)) ? '0 : c_ch + 1'b1;
            end else begin
                a_row  = c_row + 1'b1;
                a_slot = (CMP_W'(c_slot) + 1'b1 >= CMP_W'(k)) ? '0 : c_slot + 1'b1;
            end
        end
    end

    assign st_we    = (r_state == S_WRITE) && usable;
    assign st_waddr = AW'(p_slot) * AW'(MAX_WIDTH) + AW'(p_col);
    assign st_raddr = AW'(r_rd_slot) * AW'(MAX_WIDTH) + AW'(r_rd_col);

    // Divider jobs: last grid column, last grid row, slot of the current row
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(w) - DIV_W'(k);
        div_req.divisor  = s;
        unique case (r_state)
            S_FIX: begin
                div_req.start = usable && !cfg_wr;
            end
            S_DCOL: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = DIV_W'(h) - DIV_W'(k);
            end
            S_DROW: begin
                div_req.start    = div_rsp.done;
                div_req.dividend = DIV_W'(r_row);
                div_req.divisor  = k;
            end
            default: ;
        endcase
    end

    assign s_tready = (r_state == S_IDLE) && !cfg_wr;
    assign emit_go  = (r_state == S_EMIT) && (!r_out_vld || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FIX;
            r_col   <= '0;
            r_row   <= '0;
            r_ch    <= '0;
            r_cph   <= '0;
            r_rph   <= '0;
            r_slot  <= '0;
            r_cmp   <= '0;
        end else begin
            r_cmp.vld   <= (r_state == S_SCAN);
            r_cmp.first <= (r_kx == '0) && (r_ky == '0);
            r_cmp.idx   <= r_idx;
            if (cfg_wr) begin
                // any register write re-derives the grid limits and the slot
                r_state <= S_FIX;
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (s_tvalid && s_tready) begin
                            r_state <= S_WRITE;
                        end
                    end
                    S_WRITE: begin
                        if (!usable) begin
                            if (r_fs) begin
                                r_col  <= '0;
                                r_row  <= '0;
                                r_ch   <= '0;
                                r_cph  <= '0;
                                r_rph  <= '0;
                                r_slot <= '0;
                            end
                            r_state <= S_IDLE;
                        end else if (on_grid) begin
                            // hold the position; it advances when the result is loaded into the result register
                            r_col  <= p_col;
                            r_row  <= p_row;
                            r_ch   <= p_ch;
                            r_cph  <= p_cph;
                            r_rph  <= p_rph;
                            r_slot <= p_slot;
                            r_state <= S_BASE;
                        end else begin
                            r_col  <= a_col;
                            r_row  <= a_row;
                            r_ch   <= a_ch;
                            r_cph  <= a_cph;
                            r_rph  <= a_rph;
                            r_slot <= a_slot;
                            r_state <= S_IDLE;
                        end
                    end
                    S_BASE: begin
                        r_state <= S_SCAN;
                    end
                    S_SCAN: begin
                        if (CMP_W'(r_kx) + 1'b1 == CMP_W'(k)) begin
                            if (CMP_W'(r_ky) + 1'b1 == CMP_W'(k)) begin
                                r_state <= S_DRAIN;
                            end
                        end
                    end
                    S_DRAIN: begin
                        r_state <= S_EMIT;
                    end
                    S_EMIT: begin
                        if (emit_go) begin
                            r_col  <= a_col;
                            r_row  <= a_row;
                            r_ch   <= a_ch;
                            r_cph  <= a_cph;
                            r_rph  <= a_rph;
                            r_slot <= a_slot;
                            r_state <= S_IDLE;
                        end
                    end
                    S_FIX: begin
                        r_state <= usable ? S_DCOL : S_IDLE;
                    end
                    S_DCOL: begin
                        if (div_rsp.done) begin
                            r_state <= S_DROW;
                        end
                    end
                    S_DROW: begin
                        if (div_rsp.done) begin
                            r_state <= S_DSLOT;
                        end
                    end
                    S_DSLOT: begin
                        if (div_rsp.done) begin
                            r_slot  <= SW'(div_rsp.remainder);
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_FIX;
                endcase
            end
        end
    end

    // Payload and scan datapath
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_sample <= s_tdata;
            r_fs     <= s_tuser[0];
        end
        if ((r_state == S_DCOL) && div_rsp.done) begin
            r_last_col <= CMP_W'(k) - 1'b1 + CMP_W'(CMP_W'(div_rsp.quotient) * CMP_W'(s));
        end
        if ((r_state == S_DROW) && div_rsp.done) begin
            r_last_row <= CMP_W'(k) - 1'b1 + CMP_W'(CMP_W'(div_rsp.quotient) * CMP_W'(s));
        end
        if (r_state == S_WRITE) begin
            r_last    <= (CMP_W'(p_ch) + 1'b1 == CMP_W'(cc)) &&
                         (CMP_W'(p_row) == r_last_row) && (CMP_W'(p_col) == r_last_col);
            r_mul_a   <= IDX_W'(p_ch) * IDX_W'(h) +
                         IDX_W'(CMP_W'(p_row) + 1'b1 - CMP_W'(k));
            r_left    <= CW'(CMP_W'(p_col) + 1'b1 - CMP_W'(k));
            r_rd_col  <= CW'(CMP_W'(p_col) + 1'b1 - CMP_W'(k));
            r_rd_slot <= (CMP_W'(p_slot) + 1'b1 >= CMP_W'(k)) ? '0 : p_slot + 1'b1;
            r_kx      <= '0;
            r_ky      <= '0;
        end
        if (r_state == S_BASE) begin
            r_idx <= r_mul_a * IDX_W'(w) + IDX_W'(r_left);
        end
        if (r_state == S_SCAN) begin
            if (CMP_W'(r_kx) + 1'b1 == CMP_W'(k)) begin
                // wrap to the next window row
                r_kx      <= '0;
                r_ky      <= r_ky + 1'b1;
                r_rd_col  <= r_left;
                r_idx     <= r_idx + IDX_W'(w) - IDX_W'(k) + 1'b1;
                r_rd_slot <= (CMP_W'(r_rd_slot) + 1'b1 >= CMP_W'(k)) ? '0 : r_rd_slot + 1'b1;
            end else begin
                r_kx     <= r_kx + 1'b1;
                r_rd_col <= r_rd_col + 1'b1;
                r_idx    <= r_idx + 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_go) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_val  <= best_val;
            r_out_idx  <= best_idx;
            r_out_last <= r_last;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {2'b00, r_out_idx, r_out_val};
    assign m_tlast  = r_out_last;

    a_cmp_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp.vld |-> $past(r_state == S_SCAN))
        else $error("compare unit fed outside the window scan");

    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((CMP_W'(r_kx) < CMP_W'(k)) && (CMP_W'(r_ky) < CMP_W'(k))))
        else $error("scan offset beyond the window");

    a_load_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_EMIT))
        else $error("result register loaded outside the emit state");

    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tready && usable) |-> !div_rsp.busy)
        else $error("sample taken while the divider is still busy");

    a_slot_below_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && usable) |-> (CMP_W'(r_slot) < CMP_W'(k)))
        else $error("row store slot out of range");

endmodule

// ----- rtl/mp2d_apb_regs.sv -----
// Configuration registers of the max pooling block behind an APB-style port.
`timescale 1ns / 1ps

module mp2d_apb_regs import mp2d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg,
    output logic        o_wr
);

    t_cfg r_cfg;

    assign pready = 1'b1;
    assign o_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count <= 7'd1;
            r_cfg.image_width   <= 9'd28;
            r_cfg.image_height  <= 9'd28;
            r_cfg.window_size   <= 4'd2;
            r_cfg.step_size     <= 4'd2;
        end else if (o_wr) begin
            unique case (paddr[4:2])
                REG_CHANNELS: r_cfg.channel_count <= pwdata[6:0];
                REG_WIDTH:    r_cfg.image_width   <= pwdata[8:0];
                REG_HEIGHT:   r_cfg.image_height  <= pwdata[8:0];
                REG_WINDOW:   r_cfg.window_size   <= pwdata[3:0];
                REG_STEP:     r_cfg.step_size     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_CHANNELS: prdata = {25'd0, r_cfg.channel_count};
            REG_WIDTH:    prdata = {23'd0, r_cfg.image_width};
            REG_HEIGHT:   prdata = {23'd0, r_cfg.image_height};
            REG_WINDOW:   prdata = {28'd0, r_cfg.window_size};
            REG_STEP:     prdata = {28'd0, r_cfg.step_size};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/mp2d_store.sv -----
// Row store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module mp2d_store import mp2d_pkg::*; #(
    parameter int DEPTH = DEF_MAX_WINDOW * DEF_MAX_WIDTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mp2d_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module mp2d_div import mp2d_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo;
    logic [3:0]       r_rem;
    logic [3:0]       r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [4:0]       sh;
    logic             ge;

    assign sh = {r_rem, r_quo[DIV_W-1]};
    assign ge = sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            // restart drops any division in flight
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= 4'd0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? 4'(sh - {1'b0, r_dvs}) : sh[3:0];
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ----- rtl/mp2d_max.sv -----
// Running maximum over the window scan; the first of equal values is kept.
`timescale 1ns / 1ps

module mp2d_max import mp2d_pkg::*; (
    input  logic              i_clk,
    input  t_cmp_ctl          i_ctl,
    input  logic [DATA_W-1:0] i_data,
    output logic [DATA_W-1:0] o_best,
    output logic [IDX_W-1:0]  o_best_idx
);

    logic [DATA_W-1:0] r_best;
    logic [IDX_W-1:0]  r_best_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld && (i_ctl.first || ($signed(i_data) > $signed(r_best)))) begin
            r_best     <= i_data;
            r_best_idx <= i_ctl.idx;
        end
    end

    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule
